FILE: rtl/core/glyph_framebuffer_renderer_assert.svh
// ----------------------------------------------------------------------------
// glyph framebuffer renderer assertion macros
// concurrent property wrappers on aclk, with and without the reset guard
// ----------------------------------------------------------------------------
`ifndef GLYPH_FRAMEBUFFER_RENDERER_ASSERT_SVH
`define GLYPH_FRAMEBUFFER_RENDERER_ASSERT_SVH

// antecedent implies consequent in the next cycle, not checked in reset
`define GFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle, checked in reset too
`define GFR_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg
// types, constants and the glyph table of the glyph framebuffer renderer
// ----------------------------------------------------------------------------
`default_nettype none

package gfr_pkg;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_SLOTS = 23;
    // six columns (glyph plus spacer), two pages each
    localparam int GLYPH_STEPS = 2 * (GLYPH_COLS + 1);
    localparam logic [GLYPH_ROWS-1:0] GLYPH_ROW_MASK = {GLYPH_ROWS{1'b1}};

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_CHAR  = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_READ_RD,
        ST_READ_OUT
    } gfr_state_t;

    typedef struct packed {
        logic load;
        logic clr_write;
        logic step_rd;
        logic step_wr;
        logic read_rd;
        logic out_load;
    } gfr_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic step_last;
        logic out_busy;
    } gfr_status_t;

    localparam logic [7:0] FONT_ROM [0:GLYPH_SLOTS-1][0:GLYPH_COLS-1] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h60, 8'h60, 8'h00},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h62, 8'h64, 8'h08, 8'h13, 8'h23},
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
        '{8'h38, 8'h40, 8'h40, 8'h20, 8'h78},
        '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // unknown codes map to the space glyph
    function automatic logic [4:0] glyph_slot(input logic [7:0] code);
        logic [4:0] slot;
        if (code >= "0" && code <= "9") begin
            slot = 5'd5 + 5'(code - "0");
        end else begin
            case (code)
                ":":     slot = 5'd1;
                ".":     slot = 5'd2;
                "-":     slot = 5'd3;
                "%":     slot = 5'd4;
                "L":     slot = 5'd15;
                "T":     slot = 5'd16;
                "H":     slot = 5'd17;
                "P":     slot = 5'd18;
                "C":     slot = 5'd19;
                "u":     slot = 5'd20;
                "x":     slot = 5'd21;
                default: slot = 5'd0;
            endcase
        end
        return slot;
    endfunction

    // spacer column and beyond read as blank
    function automatic logic [7:0] font_column(input logic [4:0] slot, input logic [2:0] col);
        logic [7:0] bits;
        if (col < 3'(GLYPH_COLS)) begin
            bits = FONT_ROM[slot][col];
        end else begin
            bits = 8'h00;
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/glyph_framebuffer_renderer.sv
// ----------------------------------------------------------------------------
// glyph_framebuffer_renderer
// page-organized monochrome framebuffer with 5x7 character drawing
// ----------------------------------------------------------------------------
// One request is worked on at a time; the store has one write port and a
// registered read port, and every drawn byte is a read-modify-write through
// ST_DRAW_RD and ST_DRAW_WR. A character covers six columns by two pages; a
// read waits for the result register to free up. A clear, and the clearing
// pass right after reset, writes one byte per cycle over all SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT / 8) bytes, 1024 at the default size, with s_tready low
// throughout. A read result waits in its own register while the next request
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_framebuffer_renderer #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_pos[8:0], y_pos[16:9], lit[17], char_code[25:18], read_index[35:26]
    input  wire logic [39:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[7:0]
    output logic [7:0]       m_tdata
);

    gfr_pkg::gfr_cmd_t    cmd;
    gfr_pkg::gfr_status_t status;
    gfr_pkg::req_t        req_type;

    assign req_type = gfr_pkg::req_t'(s_tuser);

    gfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    gfr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_req      (req_type),
        .in_x        (s_tdata[8:0]),
        .in_y        (s_tdata[16:9]),
        .in_lit      (s_tdata[17]),
        .in_char     (s_tdata[25:18]),
        .in_index    (s_tdata[35:26]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_data    (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/gfr_ctrl.sv
// ----------------------------------------------------------------------------
// gfr_ctrl
// request sequencer: clear sweep, read-modify-write steps and byte reads
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire gfr_pkg::req_t        req_type,
    input  wire gfr_pkg::gfr_status_t status,
    output gfr_pkg::gfr_cmd_t         cmd
);

    gfr_pkg::gfr_state_t state_reg;
    gfr_pkg::gfr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gfr_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            gfr_pkg::ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (status.clr_last) begin
                    state_next = gfr_pkg::ST_IDLE;
                end
            end
            gfr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (req_type)
                        gfr_pkg::REQ_CLEAR: state_next = gfr_pkg::ST_CLEAR;
                        gfr_pkg::REQ_PIXEL: state_next = gfr_pkg::ST_DRAW_RD;
                        gfr_pkg::REQ_CHAR:  state_next = gfr_pkg::ST_DRAW_RD;
                        gfr_pkg::REQ_READ:  state_next = gfr_pkg::ST_READ_RD;
                        default:            state_next = gfr_pkg::ST_IDLE;
                    endcase
                end
            end
            gfr_pkg::ST_DRAW_RD: begin
                cmd.step_rd = 1'b1;
                state_next  = gfr_pkg::ST_DRAW_WR;
            end
            gfr_pkg::ST_DRAW_WR: begin
                cmd.step_wr = 1'b1;
                if (status.step_last) begin
                    state_next = gfr_pkg::ST_IDLE;
                end else begin
                    state_next = gfr_pkg::ST_DRAW_RD;
                end
            end
            gfr_pkg::ST_READ_RD: begin
                cmd.read_rd = 1'b1;
                state_next  = gfr_pkg::ST_READ_OUT;
            end
            gfr_pkg::ST_READ_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = gfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gfr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/gfr_datapath.sv
// ----------------------------------------------------------------------------
// gfr_datapath
// frame store, step address and mask generation, clear counter, output register
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_datapath #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire gfr_pkg::gfr_cmd_t    cmd,
    output gfr_pkg::gfr_status_t      status,
    input  wire gfr_pkg::req_t        in_req,
    input  wire logic [8:0]           in_x,
    input  wire logic [7:0]           in_y,
    input  wire logic                 in_lit,
    input  wire logic [7:0]           in_char,
    input  wire logic [9:0]           in_index,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [7:0]                out_data
);

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int RIW        = ((AW > 10) ? AW : 10) + 1;
    localparam int ROW_REM    = SCREEN_HEIGHT % 8;
    localparam logic [7:0] LAST_ROW_MASK = (ROW_REM == 0) ? 8'hFF : 8'((1 << ROW_REM) - 1);

    logic [7:0]    mem [STORE_SIZE];

    logic [8:0]    x_reg;
    logic [7:0]    y_reg;
    logic          lit_reg;
    logic [4:0]    slot_reg;
    logic          is_char_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          rd_oor_reg;
    logic [3:0]    seq_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] waddr_reg;
    logic [7:0]    wmask_reg;
    logic [7:0]    wval_reg;
    logic          wok_reg;
    logic [7:0]    rdata_reg;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;

    logic [RIW-1:0] ridx_ext;
    logic [2:0]     col;
    logic           half;
    logic [9:0]     cx;
    logic [5:0]     pg;
    logic           col_ok;
    logic           page_ok;
    logic [6:0]     glyph_col;
    logic [6:0]     pat7;
    logic [6:0]     msk7;
    logic [15:0]    m16;
    logic [15:0]    v16;
    logic [7:0]     row_mask;
    logic [7:0]     step_mask;
    logic [7:0]     step_val;
    logic [AW-1:0]  step_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rmw_data;

    assign ridx_ext = RIW'(in_index);

    // step geometry: column and page of the byte under work
    assign col     = is_char_reg ? seq_reg[3:1] : 3'd0;
    assign half    = is_char_reg & seq_reg[0];
    assign cx      = {x_reg[8], x_reg} + {7'd0, col};
    assign pg      = {y_reg[7], y_reg[7:3]} + {5'd0, half};
    assign col_ok  = !cx[9] && (cx < 10'(SCREEN_WIDTH));
    assign page_ok = !pg[5] && (pg < 6'(PAGE_COUNT));

    assign glyph_col = 7'(gfr_pkg::font_column(slot_reg, col));
    assign pat7 = is_char_reg ? glyph_col : {6'd0, lit_reg};
    assign msk7 = is_char_reg ? gfr_pkg::GLYPH_ROW_MASK : 7'd1;
    assign m16  = 16'(msk7) << y_reg[2:0];
    assign v16  = 16'(pat7) << y_reg[2:0];

    // rows past the screen bottom in the last page
    assign row_mask  = (pg[3:0] == 4'(PAGE_COUNT - 1)) ? LAST_ROW_MASK : 8'hFF;
    assign step_mask = (half ? m16[15:8] : m16[7:0]) & row_mask;
    assign step_val  = half ? v16[15:8] : v16[7:0];
    assign step_addr = AW'(32'(pg[3:0]) * 32'(SCREEN_WIDTH) + 32'(cx[8:0]));

    assign rd_en    = cmd.step_rd | cmd.read_rd;
    assign rd_addr  = cmd.read_rd ? rd_addr_reg : step_addr;
    assign rmw_data = (rdata_reg & ~wmask_reg) | (wval_reg & wmask_reg);

    assign status.clr_last  = (clr_cnt_reg == AW'(STORE_SIZE - 1));
    assign status.step_last = !is_char_reg || (seq_reg == 4'(gfr_pkg::GLYPH_STEPS - 1));
    assign status.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg        <= in_x;
            y_reg        <= in_y;
            lit_reg      <= in_lit;
            slot_reg     <= gfr_pkg::glyph_slot(in_char);
            is_char_reg  <= (in_req == gfr_pkg::REQ_CHAR);
            rd_addr_reg  <= ridx_ext[AW-1:0];
            rd_oor_reg   <= (ridx_ext >= RIW'(STORE_SIZE));
        end
    end

    // step and clear counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                seq_reg <= '0;
            end else if (cmd.step_wr) begin
                seq_reg <= seq_reg + 4'd1;
            end
            if (cmd.clr_write) begin
                clr_cnt_reg <= status.clr_last ? '0 : clr_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_rd) begin
            waddr_reg <= step_addr;
            wmask_reg <= step_mask;
            wval_reg  <= step_val;
            wok_reg   <= col_ok & page_ok;
        end
    end

    // frame store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.clr_write) begin
            mem[clr_cnt_reg] <= 8'h00;
        end else if (cmd.step_wr && wok_reg) begin
            mem[waddr_reg] <= rmw_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= rd_oor_reg ? 8'h00 : rdata_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gfr_checker.sv
// ----------------------------------------------------------------------------
// gfr_checker
// port-level checks of the glyph framebuffer renderer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "glyph_framebuffer_renderer_assert.svh"

module gfr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    logic s_accept;

    assign s_accept = s_tvalid & s_tready;

    `GFR_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    `GFR_ASSERT_NEXT_ALWAYS(a_reset_clears, !aresetn, !s_tready, "ready right after reset, clearing pass skipped")

    `GFR_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready, "transaction accepted on back-to-back cycles")

    `GFR_ASSERT_NEXT(a_no_early_result, s_accept && !m_tvalid, !m_tvalid, "result shown one cycle after a transaction")

endmodule

bind glyph_framebuffer_renderer gfr_checker u_gfr_checker (.*);

`default_nettype wire
